// ----- hw/rtl/cbz_pkg.sv -----
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared constants and tables for the cubic Bezier point/heading/curvature
// evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbz_pkg;

  localparam int unsigned TW = 17;                 // t, Q1.16
  localparam logic [TW-1:0] T_ONE = 17'd65536;

  // heading datapath
  localparam int unsigned HW        = 45;          // CORDIC x/y width
  localparam int unsigned ZW        = 28;          // angle accumulator
  localparam int unsigned NORM_BIT  = 40;          // normalise to [2^40, 2^41)
  localparam int signed   HALF_PI_Z = 26353589;
  localparam int signed   HEAD_LIM  = 25736;

  // curvature datapath
  localparam int unsigned FD_BITS = 26;            // |first deriv| < 2^26
  localparam int unsigned SD_BITS = 29;            // |second deriv| < 2^29
  localparam int unsigned AW      = FD_BITS + 1;
  localparam int unsigned BW      = SD_BITS + 1;
  localparam int unsigned SCW     = 4;             // scale shift width
  localparam int unsigned SQW     = 53;            // dx^2 + dy^2
  localparam int unsigned NW      = 58;            // cross product
  localparam int unsigned RTW     = 32;            // isqrt result
  localparam int unsigned RMW     = 66;            // isqrt remainder
  localparam int unsigned SQLO    = 27;            // split for S*R
  localparam int unsigned DENW    = 85;
  localparam int unsigned NUMW    = 88;
  localparam int unsigned QW      = 34;
  localparam int unsigned DSHW    = 120;

  // curvature pipe: scale, shift, mul, add, isqrt, two mul, divide, finish
  localparam int unsigned CLAT = 4 + RTW + 2 + QW + 1;

  typedef logic signed [ZW-1:0] ang_t;

  // arctan(2^-i) in radians * 2^24
  function automatic ang_t atan_z(input int unsigned i);
    ang_t r;
    case (i)
      0: r = 28'sd13176795;
      1: r = 28'sd7778716;
      2: r = 28'sd4110060;
      3: r = 28'sd2086331;
      4: r = 28'sd1047214;
      5: r = 28'sd524117;
      6: r = 28'sd262123;
      7: r = 28'sd131069;
      default: r = (i <= 24) ? ang_t'(28'sd1 <<< (24 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cbz_front.sv -----
// ----------------------------------------------------------------------------
// cbz_front
// Takes t, clamps it to 1.0 and queues it for the evaluation pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module cbz_front
  import cbz_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [TW-1:0] in_sample_t,
  output logic               busy,
  output logic               q_valid,
  output logic [TW-1:0]      q_t
);

  logic [TW-1:0] ent_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;
  logic [TW-1:0] t_clamp;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign pop     = (cnt_r != 2'd0);      // back end never stalls
  assign q_valid = pop;
  assign q_t     = ent_r[rp_r];
  assign t_clamp = (in_sample_t > T_ONE) ? T_ONE : in_sample_t;

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= t_clamp;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cbz_poly.sv -----
// ----------------------------------------------------------------------------
// cbz_poly
// Three de Casteljau levels: point, first and second derivative.
// ----------------------------------------------------------------------------
`default_nettype none

module cbz_poly
  import cbz_pkg::*;
#(
  parameter int CW = 24
)
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic [TW-1:0]          in_t,
  input  wire logic signed [CW-1:0]   px [4],
  input  wire logic signed [CW-1:0]   py [4],
  output logic                        out_valid,
  output logic signed [CW-1:0]        pos_x,
  output logic signed [CW-1:0]        pos_y,
  output logic signed [CW+5:0]        dx,
  output logic signed [CW+5:0]        dy,
  output logic signed [CW+5:0]        ddx,
  output logic signed [CW+5:0]        ddy
);

  localparam int LW  = CW + 3;
  localparam int DW  = LW + 3;
  localparam int PRW = LW + 19;

  typedef logic signed [LW-1:0]  lv_t;
  typedef logic signed [PRW-1:0] pr_t;

  function automatic pr_t lmul(input lv_t a, input lv_t b, input logic [TW-1:0] t);
    logic signed [LW:0] df;
    logic signed [TW:0] ts;
    df = (LW+1)'(b) - (LW+1)'(a);
    ts = signed'({1'b0, t});
    return df * ts;
  endfunction

  function automatic lv_t lfin(input lv_t a, input pr_t m);
    pr_t r;
    r = (m + PRW'(32768)) >>> 16;
    return a + LW'(r);
  endfunction

  lv_t ca [2][6];
  lv_t cb [2][6];
  lv_t pa_r [2][6];
  lv_t pb_r [2][6];

  logic [5:0]    vld_r;
  logic [TW-1:0] t1a_r, t1b_r, t2a_r, t2b_r;
  lv_t a1_r [2][6];
  pr_t m1_r [2][6];
  lv_t v1_r [2][6];
  lv_t a2_r [2][3];
  pr_t m2_r [2][3];
  lv_t c2_r [2];
  lv_t v2_r [2][4];
  lv_t a3_r [2];
  pr_t m3_r [2];
  lv_t d3_r [2];
  lv_t s3_r [2];
  lv_t v3 [2];
  logic signed [CW-1:0] pos_r [2];
  logic signed [DW-1:0] d_r [2];
  logic signed [DW-1:0] dd_r [2];

  // operand pairs: three point spans, two difference spans, one second diff
  always_comb begin
    lv_t p [4];
    lv_t d [3];
    for (int ax = 0; ax < 2; ax++) begin
      for (int i = 0; i < 4; i++) begin
        p[i] = (ax == 0) ? LW'(px[i]) : LW'(py[i]);
      end
      for (int i = 0; i < 3; i++) begin
        d[i] = p[i+1] - p[i];
      end
      ca[ax][0] = p[0];        cb[ax][0] = p[1];
      ca[ax][1] = p[1];        cb[ax][1] = p[2];
      ca[ax][2] = p[2];        cb[ax][2] = p[3];
      ca[ax][3] = d[0];        cb[ax][3] = d[1];
      ca[ax][4] = d[1];        cb[ax][4] = d[2];
      ca[ax][5] = d[1] - d[0]; cb[ax][5] = d[2] - d[1];
    end
  end

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      v3[ax] = lfin(a3_r[ax], m3_r[ax]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    pa_r  <= ca;
    pb_r  <= cb;
    t1a_r <= in_t;
    t1b_r <= t1a_r;
    t2a_r <= t1b_r;
    t2b_r <= t2a_r;
    for (int ax = 0; ax < 2; ax++) begin
      for (int k = 0; k < 6; k++) begin
        a1_r[ax][k] <= pa_r[ax][k];
        m1_r[ax][k] <= lmul(pa_r[ax][k], pb_r[ax][k], in_t);
        v1_r[ax][k] <= lfin(a1_r[ax][k], m1_r[ax][k]);
      end
      a2_r[ax][0] <= v1_r[ax][0];
      m2_r[ax][0] <= lmul(v1_r[ax][0], v1_r[ax][1], t1b_r);
      a2_r[ax][1] <= v1_r[ax][1];
      m2_r[ax][1] <= lmul(v1_r[ax][1], v1_r[ax][2], t1b_r);
      a2_r[ax][2] <= v1_r[ax][3];
      m2_r[ax][2] <= lmul(v1_r[ax][3], v1_r[ax][4], t1b_r);
      c2_r[ax]    <= v1_r[ax][5];
      for (int k = 0; k < 3; k++) begin
        v2_r[ax][k] <= lfin(a2_r[ax][k], m2_r[ax][k]);
      end
      v2_r[ax][3] <= c2_r[ax];
      a3_r[ax]    <= v2_r[ax][0];
      m3_r[ax]    <= lmul(v2_r[ax][0], v2_r[ax][1], t2b_r);
      d3_r[ax]    <= v2_r[ax][2];
      s3_r[ax]    <= v2_r[ax][3];
      pos_r[ax]   <= CW'(v3[ax]);
      d_r[ax]     <= DW'(d3_r[ax]) * DW'(3);
      dd_r[ax]    <= DW'(s3_r[ax]) * DW'(6);
    end
  end

  assign out_valid = vld_r[5];
  assign pos_x     = pos_r[0];
  assign pos_y     = pos_r[1];
  assign dx        = d_r[0];
  assign dy        = d_r[1];
  assign ddx       = dd_r[0];
  assign ddy       = dd_r[1];

endmodule

`default_nettype wire

// ----- hw/rtl/cbz_head.sv -----
// ----------------------------------------------------------------------------
// cbz_head
// Tangent angle: normalise, quadrant fold, pipelined CORDIC vectoring.
// ----------------------------------------------------------------------------
`default_nettype none

module cbz_head
  import cbz_pkg::*;
#(
  parameter int CW = 24,
  parameter int CS = 16
)
(
  input  wire logic                 clk,
  input  wire logic signed [CW+5:0] dx,
  input  wire logic signed [CW+5:0] dy,
  output logic signed [15:0]        heading
);

  typedef logic signed [HW-1:0] hv_t;

  function automatic logic below_mag(input hv_t v, input int unsigned lb);
    hv_t lim;
    lim = hv_t'(1) <<< lb;
    return (v < lim) && (v > -lim);
  endfunction

  hv_t  n_x_r [3];
  hv_t  n_y_r [3];
  logic n_z_r [3];
  hv_t  nx [3];
  hv_t  ny [3];
  hv_t  cx_r [CS+1];
  hv_t  cy_r [CS+1];
  ang_t cz_r [CS+1];
  logic zf_r [CS+1];
  hv_t  px, py;
  ang_t pz;
  ang_t zr;
  logic signed [15:0] hd_r;

  // two binary shift steps per stage: 32/16, 8/4, 2/1
  always_comb begin
    hv_t x, y;
    int unsigned k;
    for (int s = 0; s < 3; s++) begin
      x = (s == 0) ? hv_t'(dx) : n_x_r[s-1];
      y = (s == 0) ? hv_t'(dy) : n_y_r[s-1];
      for (int j = 0; j < 2; j++) begin
        k = 32 >> (2 * s + j);
        if (below_mag(x, NORM_BIT + 1 - k) && below_mag(y, NORM_BIT + 1 - k)) begin
          x = x <<< k;
          y = y <<< k;
        end
      end
      nx[s] = x;
      ny[s] = y;
    end
  end

  always_comb begin
    px = n_x_r[2];
    py = n_y_r[2];
    pz = '0;
    if (n_x_r[2] < 0) begin
      if (n_y_r[2] >= 0) begin
        px = n_y_r[2];
        py = -n_x_r[2];
        pz = ang_t'(HALF_PI_Z);
      end else begin
        px = -n_y_r[2];
        py = n_x_r[2];
        pz = -ang_t'(HALF_PI_Z);
      end
    end
  end

  always_ff @(posedge clk) begin
    n_x_r[0] <= nx[0];
    n_y_r[0] <= ny[0];
    n_z_r[0] <= (dx == '0) && (dy == '0);
    for (int s = 1; s < 3; s++) begin
      n_x_r[s] <= nx[s];
      n_y_r[s] <= ny[s];
      n_z_r[s] <= n_z_r[s-1];
    end
    cx_r[0] <= px;
    cy_r[0] <= py;
    cz_r[0] <= pz;
    zf_r[0] <= n_z_r[2];
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (cy_r[i] >= 0) begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] + atan_z(i);
      end else begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] - atan_z(i);
      end
      zf_r[i+1] <= zf_r[i];
    end
  end

  assign zr = (cz_r[CS] + ang_t'(1024)) >>> 11;

  always_ff @(posedge clk) begin
    if (zf_r[CS]) begin
      hd_r <= '0;
    end else if (zr > ang_t'(HEAD_LIM)) begin
      hd_r <= 16'(HEAD_LIM);
    end else if (zr < -ang_t'(HEAD_LIM)) begin
      hd_r <= -16'sd25736;
    end else begin
      hd_r <= 16'(zr);
    end
  end

  assign heading = hd_r;

endmodule

`default_nettype wire

// ----- hw/rtl/cbz_curv.sv -----
// ----------------------------------------------------------------------------
// cbz_curv
// Signed curvature: range scale, products, isqrt, S*R, restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module cbz_curv
  import cbz_pkg::*;
#(
  parameter int CW = 24
)
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic signed [CW+5:0] dx,
  input  wire logic signed [CW+5:0] dy,
  input  wire logic signed [CW+5:0] ddx,
  input  wire logic signed [CW+5:0] ddy,
  output logic                      out_valid,
  output logic signed [31:0]        curvature,
  output logic                      curvature_valid
);

  localparam int DW = CW + 6;
  typedef logic signed [DW-1:0] dv_t;

  function automatic logic fits(input dv_t v, input int unsigned lb);
    logic signed [63:0] w, lim;
    w   = 64'(v);
    lim = 64'sd1 <<< lb;
    return (w < lim) && (w > -lim);
  endfunction

  logic [CLAT-1:0] vld_r;

  // scale select
  logic [SCW-1:0] sel;
  logic [SCW-1:0] s_r;
  dv_t dx_r, dy_r, ddx_r, ddy_r;
  logic signed [AW-1:0] ax_r, ay_r;
  logic signed [BW-1:0] bx_r, by_r;
  logic signed [2*AW-1:0]  pxx_r, pyy_r;
  logic signed [AW+BW-1:0] pxb_r, pyb_r;
  logic signed [NW-1:0] nsum;
  logic [SQW-1:0]       sqsum;             // unsigned: may exceed 2^52

  always_comb begin
    sel = '1;
    for (int s = 2**SCW - 1; s >= 0; s--) begin
      if (fits(dx >>> s, FD_BITS) && fits(dy >>> s, FD_BITS) &&
          fits(ddx >>> (2 * s), SD_BITS) && fits(ddy >>> (2 * s), SD_BITS)) begin
        sel = SCW'(s);
      end
    end
  end

  // isqrt pipe payload
  logic [RMW-1:0] rm_r [RTW+1];
  logic [RTW-1:0] rt_r [RTW+1];
  logic [SQW-1:0] sq_r [RTW+1];
  logic [NW-1:0]  na_r [RTW+1];
  logic           ng_r [RTW+1];
  logic           iv_r [RTW+1];

  assign nsum  = NW'(pxb_r) - NW'(pyb_r);
  assign sqsum = SQW'(pxx_r) + SQW'(pyy_r);

  always_ff @(posedge clk) begin
    s_r   <= sel;
    dx_r  <= dx;
    dy_r  <= dy;
    ddx_r <= ddx;
    ddy_r <= ddy;
    ax_r  <= AW'(dx_r >>> s_r);
    ay_r  <= AW'(dy_r >>> s_r);
    bx_r  <= BW'(ddx_r >>> {s_r, 1'b0});
    by_r  <= BW'(ddy_r >>> {s_r, 1'b0});
    pxx_r <= ax_r * ax_r;
    pyy_r <= ay_r * ay_r;
    pxb_r <= ax_r * by_r;
    pyb_r <= ay_r * bx_r;
    sq_r[0] <= sqsum;
    rm_r[0] <= {(RMW - SQW - 10)'(0), sqsum, 10'd0};
    rt_r[0] <= '0;
    na_r[0] <= (nsum < 0) ? NW'(-nsum) : NW'(nsum);
    ng_r[0] <= (nsum < 0);
    iv_r[0] <= sqsum < SQW'(7);
  end

  for (genvar k = 0; k < RTW; k++) begin : g_sqrt
    localparam int B = RTW - 1 - k;
    logic [RMW-1:0] tst;
    assign tst = (RMW'(rt_r[k]) << (B + 1)) | (RMW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rm_r[k] >= tst) begin
        rm_r[k+1] <= rm_r[k] - tst;
        rt_r[k+1] <= rt_r[k] | (RTW'(1) << B);
      end else begin
        rm_r[k+1] <= rm_r[k];
        rt_r[k+1] <= rt_r[k];
      end
      sq_r[k+1] <= sq_r[k];
      na_r[k+1] <= na_r[k];
      ng_r[k+1] <= ng_r[k];
      iv_r[k+1] <= iv_r[k];
    end
  end

  // S * R as two partial products
  logic [SQW-SQLO+RTW-1:0] ph_r;
  logic [SQLO+RTW-1:0]     pl_r;
  logic [NW-1:0] m_na_r;
  logic          m_ng_r, m_iv_r;

  logic [DENW-1:0] dn_r [QW+1];
  logic [NUMW-1:0] rq_r [QW+1];
  logic [QW-1:0]   q_r  [QW+1];
  logic            st_r [QW+1];
  logic            dg_r [QW+1];
  logic            di_r [QW+1];

  always_ff @(posedge clk) begin
    ph_r   <= sq_r[RTW][SQW-1:SQLO] * rt_r[RTW];
    pl_r   <= sq_r[RTW][SQLO-1:0] * rt_r[RTW];
    m_na_r <= na_r[RTW];
    m_ng_r <= ng_r[RTW];
    m_iv_r <= iv_r[RTW];
    dn_r[0] <= (DENW'(ph_r) << SQLO) + DENW'(pl_r);
    rq_r[0] <= {m_na_r, (NUMW - NW)'(0)};
    q_r[0]  <= '0;
    st_r[0] <= 1'b0;
    dg_r[0] <= m_ng_r;
    di_r[0] <= m_iv_r;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [DSHW-1:0] dsh, rex;
    logic            sat;
    assign dsh = DSHW'(dn_r[k]) << B;
    assign rex = DSHW'(rq_r[k]);
    if (k == 0) begin : g_sat
      assign sat = rex >= (DSHW'(dn_r[k]) << QW);
    end else begin : g_nosat
      assign sat = st_r[k];
    end
    always_ff @(posedge clk) begin
      if (rex >= dsh) begin
        rq_r[k+1] <= NUMW'(rex - dsh);
        q_r[k+1]  <= q_r[k] | (QW'(1) << B);
      end else begin
        rq_r[k+1] <= rq_r[k];
        q_r[k+1]  <= q_r[k];
      end
      dn_r[k+1] <= dn_r[k];
      st_r[k+1] <= sat;
      dg_r[k+1] <= dg_r[k];
      di_r[k+1] <= di_r[k];
    end
  end

  logic [QW:0] mag;
  logic signed [31:0] cv_r;
  logic               cvv_r;
  logic               unused_tail;

  assign mag = (QW+1)'(({1'b0, q_r[QW]} + (QW+1)'(1)) >> 1);
  assign unused_tail = ^rq_r[QW] ^ ^dn_r[QW] ^ ^rm_r[RTW];

  always_ff @(posedge clk) begin
    cvv_r <= !di_r[QW];
    if (di_r[QW]) begin
      cv_r <= '0;
    end else if (!dg_r[QW]) begin
      cv_r <= (st_r[QW] || mag > (QW+1)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                         : 32'(mag);
    end else begin
      cv_r <= (st_r[QW] || mag > (QW+1)'(32'h8000_0000)) ? 32'sh8000_0000
                                                         : 32'(0) - mag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CLAT-2:0], in_valid};
    end
  end

  assign out_valid       = vld_r[CLAT-1] | (unused_tail & 1'b0);
  assign curvature       = cv_r;
  assign curvature_valid = cvv_r;

endmodule

`default_nettype wire

// ----- hw/rtl/cubic_bezier_point_heading_curvature.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_point_heading_curvature
// Evaluates a planar cubic Bezier at t: point, tangent heading and signed
// curvature, with the four control points held in APB registers.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     start / busy               in_sample_t
//  result    out_valid (strobe)         out_pos_x/y, out_heading, out_curvature,
//                                       out_curvature_valid
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One transaction per cycle is taken; busy only rises if the two-entry queue
// fills, which it does not since the back end drains one entry every cycle.
// A result strobe passes from the accepting edge through the queue (the queue
// entry is written on that edge and read straight away), the six stages for
// the three de Casteljau levels and the curvature pipe, which is the longest
// path: 32 isqrt stages and 34 divide stages.
// Synchronous active-low reset clears the queue, the valid pipes and the
// control point registers. The receiver cannot stall: results are strobed.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_heading_curvature
  import cbz_pkg::*;
#(
  parameter int COORD_WIDTH  = 24,
  parameter int CORDIC_STEPS = 16
)
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input transaction
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [TW-1:0]                 in_sample_t,
  // result transaction
  output logic                               out_valid,
  output logic signed [COORD_WIDTH-1:0]      out_pos_x,
  output logic signed [COORD_WIDTH-1:0]      out_pos_y,
  output logic signed [15:0]                 out_heading,
  output logic signed [31:0]                 out_curvature,
  output logic                               out_curvature_valid,
  // APB configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [4:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 6;
  localparam int HLAT = CORDIC_STEPS + 5;   // heading pipe depth
  localparam int HDLY = CLAT - HLAT;        // align heading with curvature

  // ---- control point registers: p0x p0y p1x p1y p2x p2y p3x p3y ----
  logic [CW-1:0] cfg_r [8];
  logic [2:0]    cfg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = 32'(cfg_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      cfg_r[cfg_idx] <= pwdata[CW-1:0];
    end
  end

  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[i] = signed'(cfg_r[2*i]);
      py[i] = signed'(cfg_r[2*i+1]);
    end
  end

  // ---- front: accept, clamp t, queue ----
  logic          q_valid;
  logic [TW-1:0] q_t;

  cbz_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_sample_t(in_sample_t),
    .busy       (busy),
    .q_valid    (q_valid),
    .q_t        (q_t)
  );

  // ---- back: polynomial, then heading and curvature side by side ----
  logic                 pv;
  logic signed [CW-1:0] ppx, ppy;
  logic signed [DW-1:0] dx, dy, ddx, ddy;

  cbz_poly #(.CW(CW)) u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (q_valid),
    .in_t     (q_t),
    .px       (px),
    .py       (py),
    .out_valid(pv),
    .pos_x    (ppx),
    .pos_y    (ppy),
    .dx       (dx),
    .dy       (dy),
    .ddx      (ddx),
    .ddy      (ddy)
  );

  logic signed [15:0] hd;

  cbz_head #(.CW(CW), .CS(CORDIC_STEPS)) u_head (
    .clk    (clk),
    .dx     (dx),
    .dy     (dy),
    .heading(hd)
  );

  cbz_curv #(.CW(CW)) u_curv (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (pv),
    .dx             (dx),
    .dy             (dy),
    .ddx            (ddx),
    .ddy            (ddy),
    .out_valid      (out_valid),
    .curvature      (out_curvature),
    .curvature_valid(out_curvature_valid)
  );

  // ---- delay lines so point and heading line up with curvature ----
  logic signed [CW-1:0] pxd_r [CLAT];
  logic signed [CW-1:0] pyd_r [CLAT];
  logic signed [15:0]   hdd_r [HDLY];

  always_ff @(posedge clk) begin
    pxd_r[0] <= ppx;
    pyd_r[0] <= ppy;
    for (int i = 1; i < CLAT; i++) begin
      pxd_r[i] <= pxd_r[i-1];
      pyd_r[i] <= pyd_r[i-1];
    end
    hdd_r[0] <= hd;
    for (int i = 1; i < HDLY; i++) begin
      hdd_r[i] <= hdd_r[i-1];
    end
  end

  assign out_pos_x   = pxd_r[CLAT-1];
  assign out_pos_y   = pyd_r[CLAT-1];
  assign out_heading = hdd_r[HDLY-1];

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb - cubic Bezier point / heading / curvature evaluator
// Self-checking bench: writes control points over APB while the block is
// idle, streams t values through start/busy with random idle bursts, and
// compares every strobed result against an in-bench bit-exact predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import cbz_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = 24;
  localparam int STEPS     = 16;
  localparam int NPTS      = 8;          // eight coordinate registers
  localparam int LAT       = CLAT + 6;   // accepting edge to strobe
  localparam int LIMIT_CYC = 600000;

  // register indexes, byte address is 4*index
  typedef enum int {P0X, P0Y, P1X, P1Y, P2X, P2Y, P3X, P3Y} reg_idx_e;

  typedef struct {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [15:0]   heading;
    logic signed [31:0]   curvature;
    logic                 curv_ok;
  } sample_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [TW-1:0] in_sample_t = '0;
  logic out_valid;
  logic signed [CW-1:0] out_pos_x, out_pos_y;
  logic signed [15:0] out_heading;
  logic signed [31:0] out_curvature;
  logic out_curvature_valid;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cubic_bezier_point_heading_curvature #(.COORD_WIDTH(CW), .CORDIC_STEPS(STEPS)) dut (
    .clk, .rst_n, .start, .busy, .in_sample_t,
    .out_valid, .out_pos_x, .out_pos_y, .out_heading, .out_curvature,
    .out_curvature_valid, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial forever #6 clk = ~clk;

  // control point shadow, updated as each APB write lands
  logic signed [CW-1:0] ctrl_pts [NPTS];

  logic [TW-1:0] t_pending [$];    // t values still to be sent
  sample_res_t   curve_expected [$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  cycles = 0;
  int  idle_left = 0;
  bit  idling_on = 1'b1;
  bit  took = 1'b0;
  int  valid_curv = 0;

  // arctan(2^-i) in radians * 2^24
  longint atan_lut [8] = '{13176795, 7778716, 4110060, 2086331,
                           1047214, 524117, 262123, 131069};

  // append a t value to the send queue
  function automatic void queue_t(logic [TW-1:0] v);
    t_pending = {t_pending, v};
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + (((b - a) * t + 32768) >>> 16);
  endfunction

  function automatic longint heading_q13(longint x, longint y);
    longint z, tmp, xs, ys, r, ang;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while ((x < 0 ? -x : x) < (64'sd1 <<< 40) && (y < 0 ? -y : y) < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
    end
    // fold into the right half-plane
    if (x < 0) begin
      tmp = x;
      if (y >= 0) begin x = y;  y = -tmp; z = HALF_PI_Z;  end
      else        begin x = -y; y = tmp;  z = -HALF_PI_Z; end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs  = x >>> i;
      ys  = y >>> i;
      ang = (i < 8) ? atan_lut[i] : ((i <= 24) ? (64'sd1 <<< (24 - i)) : 0);
      if (y >= 0) begin x += ys; y -= xs; z += ang; end
      else        begin x -= ys; y += xs; z -= ang; end
    end
    r = (z + 1024) >>> 11;
    if (r > HEAD_LIM) r = HEAD_LIM;
    if (r < -HEAD_LIM) r = -HEAD_LIM;
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin v -= res + bt; res = (res >> 1) + bt; end
      else res >>= 1;
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic void signed_curvature(input longint dx, dy, ddx, ddy,
                                           output longint cv, output logic ok);
    int s;
    longint ax, ay, bx, by, n, mag;
    longint unsigned sq, rt;
    logic [127:0] num, den, q;
    s = 0;
    forever begin
      ax = dx >>> s; ay = dy >>> s;
      bx = ddx >>> (2 * s); by = ddy >>> (2 * s);
      if ((ax < 0 ? -ax : ax) < (64'sd1 <<< FD_BITS) && (ay < 0 ? -ay : ay) < (64'sd1 <<< FD_BITS)
          && (bx < 0 ? -bx : bx) < (64'sd1 <<< SD_BITS)
          && (by < 0 ? -by : by) < (64'sd1 <<< SD_BITS)) break;
      s++;
    end
    sq = ax * ax + ay * ay;
    if (sq < 7) begin
      cv = 0; ok = 1'b0;
      return;
    end
    ok  = 1'b1;
    n   = ax * by - ay * bx;
    rt  = int_sqrt(sq << 10);
    den = 128'(sq) * 128'(rt);
    num = 128'(n < 0 ? -n : n) << 30;
    if (num >= (den << 34)) mag = 64'sd1 <<< 40;   // forces saturation below
    else begin
      q   = num / den;
      mag = longint'((q + 1) >> 1);
    end
    if (n >= 0) cv = (mag > 64'sd2147483647) ? 64'sd2147483647 : mag;
    else        cv = (mag > 64'sd2147483648) ? -64'sd2147483648 : -mag;
  endfunction

  function automatic sample_res_t bezier_eval(logic [TW-1:0] t_raw);
    sample_res_t r;
    longint px [4], py [4];
    longint t, ax, ay, bx, by, cx, cy, dx, dy, ddx, ddy, cv;
    longint dx0, dx1, dx2, dy0, dy1, dy2;
    logic ok;
    for (int i = 0; i < 4; i++) begin
      px[i] = ctrl_pts[2*i];
      py[i] = ctrl_pts[2*i+1];
    end
    t = (t_raw > T_ONE) ? 65536 : t_raw;   // t above 1.0 clamps
    ax = blend(px[0], px[1], t); bx = blend(px[1], px[2], t); cx = blend(px[2], px[3], t);
    ay = blend(py[0], py[1], t); by = blend(py[1], py[2], t); cy = blend(py[2], py[3], t);
    ax = blend(ax, bx, t); bx = blend(bx, cx, t);
    ay = blend(ay, by, t); by = blend(by, cy, t);
    cx = blend(ax, bx, t);
    cy = blend(ay, by, t);
    dx0 = px[1] - px[0]; dx1 = px[2] - px[1]; dx2 = px[3] - px[2];
    dy0 = py[1] - py[0]; dy1 = py[2] - py[1]; dy2 = py[3] - py[2];
    dx  = 3 * blend(blend(dx0, dx1, t), blend(dx1, dx2, t), t);
    dy  = 3 * blend(blend(dy0, dy1, t), blend(dy1, dy2, t), t);
    ddx = 6 * blend(dx1 - dx0, dx2 - dx1, t);
    ddy = 6 * blend(dy1 - dy0, dy2 - dy1, t);
    signed_curvature(dx, dy, ddx, ddy, cv, ok);
    r.pos_x     = cx[CW-1:0];
    r.pos_y     = cy[CW-1:0];
    r.heading   = 16'(heading_q13(dx, dy));
    r.curvature = cv[31:0];
    r.curv_ok   = ok;
    return r;
  endfunction

  // driver: inputs move on the falling edge, with random idle bursts
  always @(negedge clk) begin
    if (took) begin
      void'(t_pending.pop_front());
      took = 1'b0;
    end
    if (idle_left == 0 && idling_on && $urandom_range(0, 7) == 0)
      idle_left = $urandom_range(1, 19);
    if (idle_left > 0) begin
      idle_left--;
      start = 1'b0;
    end else if (t_pending.size() > 0) begin
      start = 1'b1;
      in_sample_t = t_pending[0];
    end else
      start = 1'b0;
  end

  // acceptance and result check on the rising edge
  always @(posedge clk) begin
    sample_res_t e;
    cycles++;
    if (rst_n && start && !busy) begin
      curve_expected = {curve_expected, bezier_eval(in_sample_t)};
      took = 1'b1;
    end
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_curvature_valid) valid_curv++;
      if (curve_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at cycle %0d", cycles);
      end else begin
        e = curve_expected.pop_front();
        if (out_pos_x !== e.pos_x || out_pos_y !== e.pos_y || out_heading !== e.heading ||
            out_curvature !== e.curvature || out_curvature_valid !== e.curv_ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp x=%0d y=%0d hd=%0d cv=%0d ok=%0b got x=%0d y=%0d hd=%0d cv=%0d ok=%0b",
                     results_seen, e.pos_x, e.pos_y, e.heading, e.curvature, e.curv_ok,
                     out_pos_x, out_pos_y, out_heading, out_curvature, out_curvature_valid);
        end
      end
    end
    if (cycles > LIMIT_CYC) begin
      $display("FAILURE");
      $finish;
    end
  end

  // APB write: setup then access, lands on the edge inside the access cycle
  task automatic apb_write(reg_idx_e idx, logic signed [CW-1:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 5'(4 * int'(idx)); pwdata = 32'(val);   // sign-extended
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    ctrl_pts[idx] = val;
  endtask

  // block idle: queue sent, every expected result back, pipe flushed
  task automatic drain();
    wait (t_pending.size() == 0 && !took);
    wait (curve_expected.size() == 0);
    repeat (LAT + 5) @(negedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int kind);
    case (kind)
      0: return CW'($urandom);                                  // anywhere
      1: return CW'($signed($urandom_range(0, 8000)) - 4000);   // modest curve
      2: return CW'($signed($urandom_range(0, 6)) - 3);         // near-degenerate
      default: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
    endcase
  endfunction

  function automatic logic [TW-1:0] rand_t();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return T_ONE;
    if (k == 1) return '0;
    if (k == 2) return TW'($urandom_range(65537, 131071));      // beyond 1.0, clamps
    return TW'($urandom_range(0, 65536));
  endfunction

  initial begin
    int phase_items;
    int kind;
    for (int i = 0; i < NPTS; i++) ctrl_pts[i] = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // all points at reset zero: zero derivative, heading 0, curvature invalid
    queue_t('0);
    queue_t(T_ONE);
    queue_t(17'h1FFFF);
    drain();

    // extremes of the coordinate range and a sharp bend
    apb_write(P0X, {1'b1, {(CW-1){1'b0}}}); apb_write(P0Y, {1'b1, {(CW-1){1'b0}}});
    apb_write(P1X, {1'b0, {(CW-1){1'b1}}}); apb_write(P1Y, {1'b1, {(CW-1){1'b0}}});
    apb_write(P2X, {1'b0, {(CW-1){1'b1}}}); apb_write(P2Y, {1'b0, {(CW-1){1'b1}}});
    apb_write(P3X, {1'b1, {(CW-1){1'b0}}}); apb_write(P3Y, {1'b0, {(CW-1){1'b1}}});
    queue_t('0);          queue_t(17'd1);
    queue_t(17'd32768);   queue_t(17'd65535);
    queue_t(T_ONE);       queue_t(17'd65537);
    queue_t(17'h1FFFF);   queue_t(17'h0AAAA);
    queue_t(17'h15555);
    drain();

    // collinear points along -x: heading near pi, curvature zero
    apb_write(P0X, 24'sd4000); apb_write(P0Y, 24'sd0);
    apb_write(P1X, 24'sd2000); apb_write(P1Y, 24'sd0);
    apb_write(P2X, -24'sd100); apb_write(P2Y, 24'sd0);
    apb_write(P3X, -24'sd900); apb_write(P3Y, 24'sd0);
    for (int i = 0; i <= 8; i++) queue_t(TW'(i * 8192));
    drain();

    // random control points in phases; no idling in the last one
    for (int ph = 0; ph < 16; ph++) begin
      kind = ph % 4;
      for (int r = 0; r < NPTS; r++) apb_write(reg_idx_e'(r), rand_coord(kind));
      if (ph == 15) idling_on = 1'b0;
      phase_items = 125;
      for (int i = 0; i < phase_items; i++) queue_t(rand_t());
      drain();
    end

    repeat (LAT) @(negedge clk);
    $display("covered %0d result transactions over 19 control point settings, %0d with valid curvature",
             results_seen, valid_curv);
    if (mismatches == 0 && curve_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, curve_expected.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
